// ===== rtl/core/barycentric_point_in_triangle_defines.svh =====
// Assertion macros shared by the barycentric point-in-triangle RTL.
// Depends on nothing; the including module must have i_clk and i_rst_n.
`ifndef BARYCENTRIC_POINT_IN_TRIANGLE_DEFINES_SVH
`define BARYCENTRIC_POINT_IN_TRIANGLE_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define BPIT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpit: implication check failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define BPIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpit: next-cycle check failed");

`endif

// ===== rtl/core/bpit_pkg.sv =====
// Types and constants for the barycentric point-in-triangle block.
// Depends on nothing.
package bpit_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_W    = 15;
    localparam int WEIGHT_W  = FRAC_W + 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int DET_W     = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int REM_W     = MAG_W + 1;
    localparam int DIV_STEPS = FRAC_W + 1;
    localparam int PROJ_LAT  = 5;
    localparam int SETUP_LAT = 3;
    localparam int LATENCY   = PROJ_LAT + SETUP_LAT + DIV_STEPS + 1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;

    typedef enum logic [1:0] {
        ST_INSIDE  = 2'd0,
        ST_DEGEN   = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic signed [COORD_W-1:0] vert0_z;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert1_y;
        logic signed [COORD_W-1:0] vert1_z;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert2_y;
        logic signed [COORD_W-1:0] vert2_z;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [WEIGHT_W-1:0] weight_u;
        logic [WEIGHT_W-1:0] weight_v;
        logic [WEIGHT_W-1:0] weight_w;
    } t_out_item;

    typedef struct packed {
        logic signed [DIFF_W-1:0] u1;
        logic signed [DIFF_W-1:0] u2;
        logic signed [DIFF_W-1:0] u3;
        logic signed [DIFF_W-1:0] u4;
        logic signed [DIFF_W-1:0] v1;
        logic signed [DIFF_W-1:0] v2;
        logic signed [DIFF_W-1:0] v3;
        logic signed [DIFF_W-1:0] v4;
    } t_proj;

    typedef struct packed {
        logic degen;
        logic over_u;
        logic over_v;
        logic neg_u;
        logic neg_v;
    } t_flags;

    typedef struct packed {
        logic [MAG_W-1:0] ad;
        logic [MAG_W-1:0] an_u;
        logic [MAG_W-1:0] an_v;
        t_flags           flags;
    } t_div_in;

    typedef struct packed {
        logic [WEIGHT_W-1:0] q_u;
        logic [WEIGHT_W-1:0] q_v;
        t_flags              flags;
    } t_div_out;

endpackage

// ===== rtl/core/bpit_project.sv =====
// Face normal, dominant-axis choice and projected differences, five stages.
// Depends on bpit_pkg.
module bpit_project (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bpit_pkg::t_in_item i_item,
    output logic             o_valid,
    output bpit_pkg::t_proj  o_proj
);
    import bpit_pkg::*;

    logic [PROJ_LAT-1:0]             r_v;
    t_in_item                        r_c1, r_c2, r_c3, r_c4;
    logic signed [DIFF_W-1:0]        r_d1 [3];
    logic signed [DIFF_W-1:0]        r_d2 [3];
    logic signed [PROD_W-1:0]        r_p  [6];
    logic signed [DET_W-1:0]         r_n  [3];
    logic [MAG_W-1:0]                r_m  [3];
    t_proj                           r_proj, n_proj;

    logic signed [COORD_W-1:0] a0 [3], a1 [3], a2 [3], aq [3];
    logic [1:0]                ax, bx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[PROJ_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1 <= i_item;
        r_d1[0] <= DIFF_W'(i_item.vert1_x) - DIFF_W'(i_item.vert0_x);
        r_d1[1] <= DIFF_W'(i_item.vert1_y) - DIFF_W'(i_item.vert0_y);
        r_d1[2] <= DIFF_W'(i_item.vert1_z) - DIFF_W'(i_item.vert0_z);
        r_d2[0] <= DIFF_W'(i_item.vert2_x) - DIFF_W'(i_item.vert1_x);
        r_d2[1] <= DIFF_W'(i_item.vert2_y) - DIFF_W'(i_item.vert1_y);
        r_d2[2] <= DIFF_W'(i_item.vert2_z) - DIFF_W'(i_item.vert1_z);

        r_c2 <= r_c1;
        r_p[0] <= r_d1[1] * r_d2[2];
        r_p[1] <= r_d1[2] * r_d2[1];
        r_p[2] <= r_d1[2] * r_d2[0];
        r_p[3] <= r_d1[0] * r_d2[2];
        r_p[4] <= r_d1[0] * r_d2[1];
        r_p[5] <= r_d1[1] * r_d2[0];

        r_c3 <= r_c2;
        r_n[0] <= DET_W'(r_p[0]) - DET_W'(r_p[1]);
        r_n[1] <= DET_W'(r_p[2]) - DET_W'(r_p[3]);
        r_n[2] <= DET_W'(r_p[4]) - DET_W'(r_p[5]);

        r_c4 <= r_c3;
        for (int i = 0; i < 3; i++) begin
            r_m[i] <= r_n[i][DET_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
        end

        r_proj <= n_proj;
    end

    always_comb begin
        a0 = '{r_c4.vert0_x, r_c4.vert0_y, r_c4.vert0_z};
        a1 = '{r_c4.vert1_x, r_c4.vert1_y, r_c4.vert1_z};
        a2 = '{r_c4.vert2_x, r_c4.vert2_y, r_c4.vert2_z};
        aq = '{r_c4.query_x, r_c4.query_y, r_c4.query_z};
        priority if (r_m[0] >= r_m[1] && r_m[0] >= r_m[2]) begin
            ax = 2'd1;
            bx = 2'd2;
        end else if (r_m[1] >= r_m[2]) begin
            ax = 2'd2;
            bx = 2'd0;
        end else begin
            ax = 2'd0;
            bx = 2'd1;
        end
        n_proj.u1 = DIFF_W'(a0[ax]) - DIFF_W'(a2[ax]);
        n_proj.u2 = DIFF_W'(a1[ax]) - DIFF_W'(a2[ax]);
        n_proj.u3 = DIFF_W'(aq[ax]) - DIFF_W'(a0[ax]);
        n_proj.u4 = DIFF_W'(aq[ax]) - DIFF_W'(a2[ax]);
        n_proj.v1 = DIFF_W'(a0[bx]) - DIFF_W'(a2[bx]);
        n_proj.v2 = DIFF_W'(a1[bx]) - DIFF_W'(a2[bx]);
        n_proj.v3 = DIFF_W'(aq[bx]) - DIFF_W'(a0[bx]);
        n_proj.v4 = DIFF_W'(aq[bx]) - DIFF_W'(a2[bx]);
    end

    assign o_valid = r_v[PROJ_LAT-1];
    assign o_proj  = r_proj;

endmodule

// ===== rtl/core/bpit_setup.sv =====
// Denominator and numerators of the projected system, magnitudes and flags.
// Three stages. Depends on bpit_pkg.
module bpit_setup (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bpit_pkg::t_proj   i_proj,
    output logic              o_valid,
    output bpit_pkg::t_div_in o_div
);
    import bpit_pkg::*;

    logic [SETUP_LAT-1:0]     r_v;
    logic signed [PROD_W-1:0] r_p [6];
    logic signed [DET_W-1:0]  r_den, r_nu, r_nv;
    t_div_in                  r_div, n_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[SETUP_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p[0] <= i_proj.v1 * i_proj.u2;
        r_p[1] <= i_proj.v2 * i_proj.u1;
        r_p[2] <= i_proj.v4 * i_proj.u2;
        r_p[3] <= i_proj.v2 * i_proj.u4;
        r_p[4] <= i_proj.v1 * i_proj.u3;
        r_p[5] <= i_proj.v3 * i_proj.u1;
        r_den  <= DET_W'(r_p[0]) - DET_W'(r_p[1]);
        r_nu   <= DET_W'(r_p[2]) - DET_W'(r_p[3]);
        r_nv   <= DET_W'(r_p[4]) - DET_W'(r_p[5]);
        r_div  <= n_div;
    end

    always_comb begin
        n_div.ad   = r_den[DET_W-1] ? MAG_W'(-r_den) : MAG_W'(r_den);
        n_div.an_u = r_nu[DET_W-1]  ? MAG_W'(-r_nu)  : MAG_W'(r_nu);
        n_div.an_v = r_nv[DET_W-1]  ? MAG_W'(-r_nv)  : MAG_W'(r_nv);
        n_div.flags.degen  = (r_den == '0);
        n_div.flags.over_u = {1'b0, n_div.an_u} >= {n_div.ad, 1'b0};
        n_div.flags.over_v = {1'b0, n_div.an_v} >= {n_div.ad, 1'b0};
        n_div.flags.neg_u  = (r_nu[DET_W-1] != r_den[DET_W-1]) && (r_nu != '0);
        n_div.flags.neg_v  = (r_nv[DET_W-1] != r_den[DET_W-1]) && (r_nv != '0);
    end

    assign o_valid = r_v[SETUP_LAT-1];
    assign o_div   = r_div;

endmodule

// ===== rtl/core/bpit_divide.sv =====
// Two restoring dividers side by side, one quotient bit per stage.
// Depends on bpit_pkg.
module bpit_divide (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bpit_pkg::t_div_in  i_div,
    output logic               o_valid,
    output bpit_pkg::t_div_out o_quot
);
    import bpit_pkg::*;

    logic [DIV_STEPS-1:0] r_v;
    logic [MAG_W-1:0]     r_ad    [DIV_STEPS];
    logic [REM_W-1:0]     r_rem_u [DIV_STEPS];
    logic [REM_W-1:0]     r_rem_v [DIV_STEPS];
    logic [WEIGHT_W-1:0]  r_q_u   [DIV_STEPS];
    logic [WEIGHT_W-1:0]  r_q_v   [DIV_STEPS];
    t_flags               r_fl    [DIV_STEPS];

    logic [REM_W-1:0]     s_u [DIV_STEPS];
    logic [REM_W-1:0]     s_v [DIV_STEPS];
    logic [MAG_W-1:0]     s_ad [DIV_STEPS];
    logic                 b_u [DIV_STEPS];
    logic                 b_v [DIV_STEPS];

    always_comb begin
        s_u[0]  = REM_W'(i_div.an_u);
        s_v[0]  = REM_W'(i_div.an_v);
        s_ad[0] = i_div.ad;
        for (int k = 1; k < DIV_STEPS; k++) begin
            s_u[k]  = {r_rem_u[k-1][REM_W-2:0], 1'b0};
            s_v[k]  = {r_rem_v[k-1][REM_W-2:0], 1'b0};
            s_ad[k] = r_ad[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            b_u[k] = s_u[k] >= REM_W'(s_ad[k]);
            b_v[k] = s_v[k] >= REM_W'(s_ad[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            r_ad[k]    <= s_ad[k];
            r_rem_u[k] <= b_u[k] ? s_u[k] - REM_W'(s_ad[k]) : s_u[k];
            r_rem_v[k] <= b_v[k] ? s_v[k] - REM_W'(s_ad[k]) : s_v[k];
        end
        r_q_u[0] <= WEIGHT_W'(b_u[0]);
        r_q_v[0] <= WEIGHT_W'(b_v[0]);
        r_fl[0]  <= i_div.flags;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_q_u[k] <= {r_q_u[k-1][WEIGHT_W-2:0], b_u[k]};
            r_q_v[k] <= {r_q_v[k-1][WEIGHT_W-2:0], b_v[k]};
            r_fl[k]  <= r_fl[k-1];
        end
    end

    assign o_valid      = r_v[DIV_STEPS-1];
    assign o_quot.q_u   = r_q_u[DIV_STEPS-1];
    assign o_quot.q_v   = r_q_v[DIV_STEPS-1];
    assign o_quot.flags = r_fl[DIV_STEPS-1];

endmodule

// ===== rtl/core/barycentric_point_in_triangle.sv =====
// Top level of the barycentric point-in-triangle test with output register.
// Depends on bpit_pkg, bpit_project, bpit_setup, bpit_divide and the defines header.
//
// Usage: drive i_item with three vertices and a query point, all signed
// Q8.8, and raise start for one cycle per item. busy is always low, so a
// new item may be given in every clock cycle and one result leaves per
// cycle. Each result appears on o_result for exactly one cycle, marked by
// o_valid, once its item has passed through the stages that form the normal
// and the projection, the stages that form the determinants, the
// restoring division (one quotient bit per stage) and the output register.
// Results leave in the order the items came in.
// o_result.status is 0 inside, 1 degenerate, 2 outside; the weights are
// unsigned Q1.15 and zero unless the point is inside.
// A synchronous low reset on i_rst_n clears all valid bits; items in flight
// are dropped. The receiver cannot stall; it must take each beat when shown.
`include "barycentric_point_in_triangle_defines.svh"
module barycentric_point_in_triangle (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bpit_pkg::t_in_item  i_item,
    output logic                o_valid,
    output bpit_pkg::t_out_item o_result
);
    import bpit_pkg::*;

    logic      p_valid, s_valid, d_valid;
    t_proj     p_proj;
    t_div_in   s_div;
    t_div_out  d_quot;

    logic                r_valid;
    t_out_item           r_result, n_result;
    logic                out_u, out_v;
    logic [WEIGHT_W:0]   sum_uv;

    logic [WEIGHT_W+1:0] sum_uvw;
    logic                sum_one, zero_w;

    bpit_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (p_valid),
        .o_proj  (p_proj)
    );

    bpit_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_proj  (p_proj),
        .o_valid (s_valid),
        .o_div   (s_div)
    );

    bpit_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid),
        .i_div   (s_div),
        .o_valid (d_valid),
        .o_quot  (d_quot)
    );

    always_comb begin
        sum_uv = {1'b0, d_quot.q_u} + {1'b0, d_quot.q_v};
        out_u  = d_quot.flags.over_u || (d_quot.flags.neg_u && d_quot.q_u != '0)
                 || d_quot.q_u > WEIGHT_ONE;
        out_v  = d_quot.flags.over_v || (d_quot.flags.neg_v && d_quot.q_v != '0)
                 || d_quot.q_v > WEIGHT_ONE;
        n_result = '0;
        priority if (d_quot.flags.degen) begin
            n_result.status = ST_DEGEN;
        end else if (out_u || out_v || sum_uv > {1'b0, WEIGHT_ONE}) begin
            n_result.status = ST_OUTSIDE;
        end else begin
            n_result.status   = ST_INSIDE;
            n_result.weight_u = d_quot.q_u;
            n_result.weight_v = d_quot.q_v;
            n_result.weight_w = WEIGHT_ONE - d_quot.q_u - d_quot.q_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = 1'b0;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign sum_uvw = {2'b0, o_result.weight_u} + {2'b0, o_result.weight_v}
                     + {2'b0, o_result.weight_w};
    assign sum_one = (sum_uvw == {2'b0, WEIGHT_ONE});
    assign zero_w  = (o_result.weight_u == '0) && (o_result.weight_v == '0)
                     && (o_result.weight_w == '0);

    `BPIT_ASSERT_IMPL(a_latency, o_valid, $past(start, LATENCY))
    `BPIT_ASSERT_IMPL(a_zero_weights, o_valid && o_result.status != ST_INSIDE, zero_w)
    `BPIT_ASSERT_IMPL(a_sum_one, o_valid && o_result.status == ST_INSIDE, sum_one)
    `BPIT_ASSERT_NEXT(a_div_to_out, d_valid, o_valid)

endmodule
